/* design/cwss_pkg.sv */
package cwss_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int DIGIT_W    = $clog2(NUM_DIGITS);

	typedef logic [4:0]         hours_t;
	typedef logic [5:0]         sixty_t;
	typedef logic [1:0]         mode_t;
	typedef logic [1:0]         key_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [15:0]        rate_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	localparam mode_t MODE_RUN      = 2'd0;
	localparam mode_t MODE_SET_MIN  = 2'd1;
	localparam mode_t MODE_SET_HOUR = 2'd2;

	localparam key_t KEY_NONE = 2'd0;
	localparam key_t KEY_MODE = 2'd1;
	localparam key_t KEY_INC  = 2'd2;

	localparam hours_t LAST_HOUR = 5'd23;
	localparam sixty_t LAST_MIN  = 6'd59;

	localparam logic [7:0] DASH_CODE  = 8'h40;
	localparam logic [7:0] BLANK_CODE = 8'h00;
	localparam rate_t      TPS_RESET  = 16'd1000;

	// register map
	localparam logic REG_TPS = 1'b0;

	localparam logic [7:0] FONT [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} bcd_t;

	// values are below 64; a compare chain stands in for the divide by ten
	function automatic bcd_t split_bcd(input sixty_t v);
		bcd_t   r;
		sixty_t base;
		if (v >= 6'd60) begin
			r.tens = 4'd6; base = 6'd60;
		end else if (v >= 6'd50) begin
			r.tens = 4'd5; base = 6'd50;
		end else if (v >= 6'd40) begin
			r.tens = 4'd4; base = 6'd40;
		end else if (v >= 6'd30) begin
			r.tens = 4'd3; base = 6'd30;
		end else if (v >= 6'd20) begin
			r.tens = 4'd2; base = 6'd20;
		end else if (v >= 6'd10) begin
			r.tens = 4'd1; base = 6'd10;
		end else begin
			r.tens = 4'd0; base = 6'd0;
		end
		r.ones = 4'(v - base);
		return r;
	endfunction

	function automatic logic [7:0] glyph(input logic [3:0] d);
		return (d < 4'd10) ? FONT[d] : BLANK_CODE;
	endfunction

endpackage

/* design/cwss_if.sv */
interface cwss_sample_if import cwss_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic key1_level;
	logic key2_level;

	modport source (output valid, cmd, key1_level, key2_level, input ready);
	modport sink   (input valid, cmd, key1_level, key2_level, output ready);
endinterface

interface cwss_display_if import cwss_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] segment_pattern;
	logic [7:0] digit_select_n;
	hours_t     hours_now;
	sixty_t     minutes_now;
	sixty_t     seconds_now;
	mode_t      mode_now;

	modport source (output valid, segment_pattern, digit_select_n, hours_now, minutes_now,
		seconds_now, mode_now, input ready);
	modport sink   (input valid, segment_pattern, digit_select_n, hours_now, minutes_now,
		seconds_now, mode_now, output ready);
endinterface

/* design/clock_with_seven_segment_scan.sv */
// An item is registered in the input register on acceptance, and a tick's result is then
// registered in the result register once that register is free, from where it is offered.
// Key samples give no result.
// Throughput: one item per cycle, set by the single time/scan update stage, unless a tick
// waits on a full result register; the input register frees once that register can take it.
// Reset: arst_n clears time, mode, key history, prescaler and scan position at once and
// loads ticks_per_second with 1000; both handshake stages come up empty.
module clock_with_seven_segment_scan import cwss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	cwss_sample_if.sink            sample,
	cwss_display_if.source         display,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [0:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// configuration
	rate_t tps_q;

	assign pready = 1'b1;
	assign prdata = (paddr[0] == REG_TPS) ? {16'd0, tps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[0] == REG_TPS) begin
			tps_q <= pwdata[15:0];
		end
	end

	// input register
	logic valid_s1;
	logic cmd_s1;
	logic key1_s1;
	logic key2_s1;
	logic out_free;
	logic advance;

	assign out_free     = !display.valid || display.ready;
	assign advance      = valid_s1 && (cmd_s1 == CMD_KEY || out_free);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			cmd_s1  <= sample.cmd;
			key1_s1 <= sample.key1_level;
			key2_s1 <= sample.key2_level;
		end
	end

	// clock state
	rate_t  tick_count_q;
	sixty_t seconds_q;
	sixty_t minutes_q;
	hours_t hours_q;
	mode_t  mode_q;
	key_t   prev_key_q;
	digit_t digit_q;

	rate_t      tick_count_d;
	sixty_t     seconds_d;
	sixty_t     minutes_d;
	hours_t     hours_d;
	mode_t      mode_d;
	key_t       prev_key_d;
	digit_t     digit_d;
	key_t       key_now;
	key_t       key_edge;
	logic [16:0] tick_next;
	logic       show_h;
	logic       show_m;
	logic       show_s;
	bcd_t       h_bcd;
	bcd_t       m_bcd;
	bcd_t       s_bcd;
	logic [7:0] pattern;

	assign h_bcd = split_bcd({1'b0, hours_q});
	assign m_bcd = split_bcd(minutes_q);
	assign s_bcd = split_bcd(seconds_q);

	assign show_h = (mode_q == MODE_RUN) || (mode_q == MODE_SET_HOUR);
	assign show_m = (mode_q == MODE_RUN) || (mode_q == MODE_SET_MIN);
	assign show_s = (mode_q == MODE_RUN);

	// layout: H H - M M - S S
	always_comb begin
		case (digit_q)
			3'd0:    pattern = show_h ? glyph(h_bcd.tens) : BLANK_CODE;
			3'd1:    pattern = show_h ? glyph(h_bcd.ones) : BLANK_CODE;
			3'd2:    pattern = show_s ? DASH_CODE : BLANK_CODE;
			3'd3:    pattern = show_m ? glyph(m_bcd.tens) : BLANK_CODE;
			3'd4:    pattern = show_m ? glyph(m_bcd.ones) : BLANK_CODE;
			3'd5:    pattern = show_s ? DASH_CODE : BLANK_CODE;
			3'd6:    pattern = show_s ? glyph(s_bcd.tens) : BLANK_CODE;
			3'd7:    pattern = show_s ? glyph(s_bcd.ones) : BLANK_CODE;
			default: pattern = BLANK_CODE;
		endcase
	end

	// key 2 wins when both are held
	assign key_now  = !key2_s1 ? KEY_INC : (!key1_s1 ? KEY_MODE : KEY_NONE);
	assign key_edge = key_now & ~prev_key_q;
	assign tick_next = {1'b0, tick_count_q} + 17'd1;

	always_comb begin
		tick_count_d = tick_count_q;
		seconds_d    = seconds_q;
		minutes_d    = minutes_q;
		hours_d      = hours_q;
		mode_d       = mode_q;
		prev_key_d   = prev_key_q;
		digit_d      = digit_q;
		if (cmd_s1 == CMD_KEY) begin
			prev_key_d = key_now;
			if (key_edge == KEY_MODE) begin
				mode_d = (mode_q >= MODE_SET_HOUR) ? MODE_RUN : mode_t'(mode_q + 2'd1);
			end else if (key_edge == KEY_INC) begin
				if (mode_q == MODE_SET_MIN) begin
					minutes_d = (minutes_q >= LAST_MIN) ? 6'd0 : sixty_t'(minutes_q + 6'd1);
				end else if (mode_q == MODE_SET_HOUR) begin
					hours_d = (hours_q >= LAST_HOUR) ? 5'd0 : hours_t'(hours_q + 5'd1);
				end
			end
		end else begin
			digit_d = digit_t'(digit_q + 3'd1);
			if (tick_next >= {1'b0, tps_q}) begin
				tick_count_d = '0;
				if (mode_q == MODE_RUN) begin
					if (seconds_q >= LAST_MIN) begin
						seconds_d = '0;
						if (minutes_q >= LAST_MIN) begin
							minutes_d = '0;
							hours_d   = (hours_q >= LAST_HOUR) ? 5'd0 : hours_t'(hours_q + 5'd1);
						end else begin
							minutes_d = sixty_t'(minutes_q + 6'd1);
						end
					end else begin
						seconds_d = sixty_t'(seconds_q + 6'd1);
					end
				end
			end else begin
				tick_count_d = tick_next[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			seconds_q    <= '0;
			minutes_q    <= '0;
			hours_q      <= '0;
			mode_q       <= MODE_RUN;
			prev_key_q   <= KEY_NONE;
			digit_q      <= '0;
		end else if (advance) begin
			tick_count_q <= tick_count_d;
			seconds_q    <= seconds_d;
			minutes_q    <= minutes_d;
			hours_q      <= hours_d;
			mode_q       <= mode_d;
			prev_key_q   <= prev_key_d;
			digit_q      <= digit_d;
		end
	end

	// result register
	logic emit;
	assign emit = advance && cmd_s1 == CMD_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display.valid <= 1'b0;
		end else if (out_free) begin
			display.valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			display.segment_pattern <= pattern;
			display.digit_select_n  <= ~(8'h01 << digit_q);
			display.hours_now       <= hours_d;
			display.minutes_now     <= minutes_d;
			display.seconds_now     <= seconds_d;
			display.mode_now        <= mode_d;
		end
	end

`ifndef SYNTHESIS
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		hours_q <= LAST_HOUR && minutes_q <= LAST_MIN && seconds_q <= LAST_MIN)
		else $error("time value out of range");

	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		display.valid |-> $onehot(~display.digit_select_n))
		else $error("digit select not one-hot");

	a_key_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cmd_s1 == CMD_KEY |=> display.valid == $past(display.valid && !display.ready))
		else $error("key sample produced a display item");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> digit_q == digit_t'($past(digit_q) + 3'd1))
		else $error("scan position did not step");
`endif

endmodule
